FILE: sv/ucm_pkg.sv
// Package: constants, types and helpers shared by the light-to-motor UART command block.
package ucm_pkg;

    localparam int OVERSAMPLE  = 8;
    localparam int CMD_BUF_LEN = 6;
    localparam int HALF_BIT    = OVERSAMPLE / 2;
    localparam int STOP_POINT  = HALF_BIT + 9 * OVERSAMPLE;
    localparam int CNT_W       = $clog2(STOP_POINT + 1);
    localparam int LEN_W       = $clog2(CMD_BUF_LEN + 1);
    localparam int DATA_BITS   = 8;

    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_STEPS   = 16;
    localparam int DIV_CW      = $clog2(DIV_STEPS);

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] SEL_LIGHT_LO = 8'h6C;
    localparam logic [7:0] SEL_LIGHT_HI = 8'h4C;
    localparam logic [7:0] SEL_MOTOR_LO = 8'h6D;
    localparam logic [7:0] SEL_MOTOR_HI = 8'h4D;
    localparam logic [7:0] MSB_SET     = 8'h80;
    localparam logic [7:0] DUTY_MAX    = 8'hFF;

    typedef struct packed {
        logic [7:0] light;
        logic [7:0] light_low;
        logic [7:0] light_high;
        logic [7:0] motor_low;
        logic [7:0] motor_high;
    } map_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_PREP,
        BK_DIV,
        BK_DONE
    } back_state_t;

    function automatic logic is_sample_point(input logic [CNT_W-1:0] c);
        logic hit;
        hit = 1'b0;
        for (int k = 1; k <= DATA_BITS; k++)
        begin
            if (c == CNT_W'(HALF_BIT + k * OVERSAMPLE))
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

FILE: sv/ucm_front.sv
// Front end: oversampled 8N1 receiver, command parser, range registers and job issue.
module ucm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic              rx_level,
    input  logic [7:0]        light_sample,
    input  ucm_pkg::fifo_status_t q_status,
    output logic              push,
    output ucm_pkg::map_job_t push_job
);
    import ucm_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [7:0]       shift_reg, shift_next;
    logic [LEN_W-1:0] len_reg, len_next, len_eff;
    logic [7:0]       b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic [7:0]       ll_reg, ll_next, lh_reg, lh_next, ml_reg, ml_next, mh_reg, mh_next;
    logic             accept, tick, byte_done;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign tick     = accept && !action;
    assign push     = accept && action;

    always_comb
    begin
        push_job.light      = light_sample;
        push_job.light_low  = ll_reg;
        push_job.light_high = lh_reg;
        push_job.motor_low  = ml_reg;
        push_job.motor_high = mh_reg;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        ll_next    = ll_reg;
        lh_next    = lh_reg;
        ml_next    = ml_reg;
        mh_next    = mh_reg;
        byte_done  = 1'b0;
        cnt_inc    = cnt_reg + CNT_W'(1);
        len_eff    = (len_reg >= LEN_W'(CMD_BUF_LEN)) ? '0 : len_reg;

        if (tick)
        begin
            if (!busy_reg)
            begin
                if (!rx_level)
                begin
                    busy_next  = 1'b1;
                    shift_next = '0;
                    cnt_next   = '0;
                end
            end
            else
            begin
                cnt_next = cnt_inc;
                if (is_sample_point(cnt_inc))
                    shift_next = (shift_reg >> 1) | (rx_level ? MSB_SET : 8'h00);
                else if (cnt_inc >= CNT_W'(STOP_POINT))
                begin
                    busy_next = 1'b0;
                    byte_done = rx_level;
                end
            end
        end

        if (byte_done)
        begin
            if (shift_reg == CHAR_LF && len_reg != LEN_W'(2))
            begin
                if (len_reg == LEN_W'(3) && b0_reg == CHAR_C)
                begin
                    case (b1_reg)
                        SEL_LIGHT_LO: ll_next = b2_reg;
                        SEL_LIGHT_HI: lh_next = b2_reg;
                        SEL_MOTOR_LO: ml_next = b2_reg;
                        SEL_MOTOR_HI: mh_next = b2_reg;
                        default: ;
                    endcase
                end
                len_next = '0;
            end
            else
            begin
                case (len_eff)
                    LEN_W'(0): b0_next = shift_reg;
                    LEN_W'(1): b1_next = shift_reg;
                    LEN_W'(2): b2_next = shift_reg;
                    default: ;
                endcase
                len_next = len_eff + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            len_reg   <= '0;
            ll_reg    <= 8'h00;
            lh_reg    <= DUTY_MAX;
            ml_reg    <= 8'h00;
            mh_reg    <= DUTY_MAX;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            ml_reg    <= ml_next;
            mh_reg    <= mh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        b2_reg <= b2_next;
    end

endmodule

FILE: sv/ucm_queue.sv
// Short job queue between the front end and the map back end.
module ucm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ucm_pkg::map_job_t     push_job,
    input  logic                  pop,
    output ucm_pkg::map_job_t     head_job,
    output ucm_pkg::fifo_status_t status
);
    import ucm_pkg::*;

    map_job_t           slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign status.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = slot_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
            wr_next = (wr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_reg + FIFO_AW'(1);
        if (do_pop)
            rd_next = (rd_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_reg + FIFO_AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + FIFO_CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

FILE: sv/ucm_back.sv
// Back end: linear range map with a bit-serial divider and a registered output word.
module ucm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ucm_pkg::fifo_status_t q_status,
    input  ucm_pkg::map_job_t     head_job,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            motor_duty
);
    import ucm_pkg::*;

    back_state_t       state_reg, state_next;
    map_job_t          job_reg;
    logic signed [17:0] prod_reg;
    logic [15:0]       quo_reg, quo_next;
    logic [7:0]        rem_reg, rem_next;
    logic [7:0]        den_reg;
    logic              neg_reg;
    logic              zero_span_reg;
    logic [DIV_CW-1:0] step_reg;
    logic              out_valid_reg;
    logic [7:0]        duty_reg;

    logic              slot_free, load_job, do_mul, do_prep, do_div, do_out;
    logic signed [8:0] span, dx, dm;
    logic [8:0]        rem_sh;
    logic [16:0]       prod_mag;
    logic signed [17:0] q_signed, r_sum;
    logic [7:0]        duty_new;

    assign slot_free  = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign motor_duty = duty_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_status.empty) state_next = BK_MUL;
            BK_MUL:  state_next = BK_PREP;
            BK_PREP: state_next = (span == 9'sd0) ? BK_DONE : BK_DIV;
            BK_DIV:  if (step_reg == DIV_CW'(DIV_STEPS - 1)) state_next = BK_DONE;
            BK_DONE: if (slot_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        load_job = 1'b0;
        do_mul   = 1'b0;
        do_prep  = 1'b0;
        do_div   = 1'b0;
        do_out   = 1'b0;
        case (state_reg)
            BK_IDLE: load_job = !q_status.empty;
            BK_MUL:  do_mul   = 1'b1;
            BK_PREP: do_prep  = 1'b1;
            BK_DIV:  do_div   = 1'b1;
            BK_DONE: do_out   = slot_free;
            default: ;
        endcase
    end

    assign pop = load_job;

    always_comb
    begin
        span     = $signed({1'b0, job_reg.light_high}) - $signed({1'b0, job_reg.light_low});
        dx       = $signed({1'b0, job_reg.light}) - $signed({1'b0, job_reg.light_low});
        dm       = $signed({1'b0, job_reg.motor_high}) - $signed({1'b0, job_reg.motor_low});
        prod_mag = prod_reg[17] ? 17'(-prod_reg) : 17'(prod_reg);
        rem_sh   = {rem_reg, quo_reg[15]};
        if (rem_sh >= {1'b0, den_reg})
        begin
            rem_next = 8'(rem_sh - {1'b0, den_reg});
            quo_next = {quo_reg[14:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[7:0];
            quo_next = {quo_reg[14:0], 1'b0};
        end
        q_signed = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        r_sum    = q_signed + $signed({10'b0, job_reg.motor_low});
        if (zero_span_reg)
            duty_new = job_reg.motor_low;
        else if (r_sum < 18'sd0)
            duty_new = 8'h00;
        else if (r_sum > 18'sd255)
            duty_new = DUTY_MAX;
        else
            duty_new = r_sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (do_prep)
                step_reg <= '0;
            else if (do_div)
                step_reg <= step_reg + DIV_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_job)
            job_reg <= head_job;
        if (do_mul)
            prod_reg <= 18'(dx) * 18'(dm);
        if (do_prep)
        begin
            zero_span_reg <= (span == 9'sd0);
            neg_reg       <= prod_reg[17] ^ span[8];
            den_reg       <= span[8] ? 8'(-span) : span[7:0];
            quo_reg       <= prod_mag[15:0];
            rem_reg       <= 8'h00;
        end
        else if (do_div)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (do_out)
            duty_reg <= duty_new;
    end

endmodule

FILE: sv/uart_command_light_to_motor_map_core.sv
// Top level: UART command receiver with light-to-motor range map.
//
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid/in_ready, action, rx_level,    | in
//           | light_sample                            |
//  output   | out_valid/out_ready, motor_duty         | out
//
// Ticks finish in the front end; it takes one word per cycle while the queue has room.
// A light sample passes through the back end as load, multiply, prepare, 16 steps of
// the one-bit-per-cycle divider (skipped for a zero light span), and the output write.
// Two queue slots let the front keep taking ticks while a map is running.
// rst_n resets the receiver, parser length, range bounds, queue and output valid.
// A stalled output word holds the back end in its final state.
module uart_command_light_to_motor_map_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic       rx_level,
    input  logic [7:0] light_sample,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] motor_duty
);
    import ucm_pkg::*;

    fifo_status_t q_status;
    map_job_t     push_job, head_job;
    logic         push, pop;

    ucm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .rx_level     (rx_level),
        .light_sample (light_sample),
        .q_status     (q_status),
        .push         (push),
        .push_job     (push_job)
    );

    ucm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    ucm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .motor_duty (motor_duty)
    );

endmodule
